FILE: sv/dels_pkg.sv
package dels_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int VAL_W     = 32;
	localparam int CNT_W     = 7;
	localparam int REQ_W     = 3;
	localparam int ST_W      = 2;
	localparam int QDEPTH    = 2;

	typedef enum logic [REQ_W-1:0] {
		OP_PUSH_BACK  = 3'd0,
		OP_PUSH_FRONT = 3'd1,
		OP_POP_BACK   = 3'd2,
		OP_POP_FRONT  = 3'd3,
		OP_TRAVERSE   = 3'd4,
		OP_LENGTH     = 3'd5
	} op_t;

	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		op_t               op;
		logic signed [VAL_W-1:0] value;
	} req_t;

	// queue side of the front/back split
	typedef struct packed {
		logic valid;
		req_t req;
	} q_head_t;

endpackage

FILE: sv/dels_front.sv
module dels_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [dels_pkg::REQ_W-1:0]          req_type,
	input  logic signed [dels_pkg::VAL_W-1:0]   push_value,
	output dels_pkg::q_head_t                   q_head,
	input  logic                                q_pop
);

	localparam int PW = $clog2(dels_pkg::QDEPTH);
	localparam int FW = $clog2(dels_pkg::QDEPTH + 1);

	dels_pkg::req_t  q_mem_q [dels_pkg::QDEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [FW-1:0]   fill_q;
	logic            known;
	logic            accept;
	logic            push;
	dels_pkg::req_t  new_req;

	assign in_stall = (fill_q == FW'(dels_pkg::QDEPTH));
	assign accept   = in_valid && !in_stall;

	// unused request codes are dropped here and never reach the back end
	always_comb begin
		unique case (dels_pkg::op_t'(req_type)) inside
			dels_pkg::OP_PUSH_BACK,
			dels_pkg::OP_PUSH_FRONT,
			dels_pkg::OP_POP_BACK,
			dels_pkg::OP_POP_FRONT,
			dels_pkg::OP_TRAVERSE,
			dels_pkg::OP_LENGTH: known = 1'b1;
			default:             known = 1'b0;
		endcase
	end

	assign push          = accept && known;
	assign new_req.op    = dels_pkg::op_t'(req_type);
	assign new_req.value = push_value;

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= new_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (push && !q_pop) begin
				fill_q <= fill_q + FW'(1);
			end else if (!push && q_pop) begin
				fill_q <= fill_q - FW'(1);
			end
		end
	end

	assign q_head.valid = (fill_q != '0);
	assign q_head.req   = q_mem_q[rd_ptr_q];

endmodule

FILE: sv/dels_back.sv
module dels_back #(
	parameter int DEPTH = dels_pkg::DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  dels_pkg::q_head_t                   q_head,
	output logic                                q_pop,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [dels_pkg::ST_W-1:0]           status,
	output logic signed [dels_pkg::VAL_W-1:0]   item_value,
	output logic [dels_pkg::CNT_W-1:0]          entry_count,
	output logic                                last
);

	localparam int IW    = $clog2(DEPTH);
	localparam int CW    = dels_pkg::CNT_W;
	localparam int SW    = CW + 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	typedef enum logic [1:0] {
		B_IDLE = 2'b01,
		B_TRAV = 2'b10
	} state_t;

	logic [dels_pkg::VAL_W-1:0] mem [DEPTH];

	state_t          state_q, state_d;
	logic [IW-1:0]   front_q, front_d;
	logic [CW-1:0]   count_q, count_d;
	logic [IW-1:0]   slot_q, slot_d;
	logic [CW-1:0]   left_q, left_d;
	logic            out_valid_q;
	logic [dels_pkg::ST_W-1:0]  status_q;
	logic [CW-1:0]   cnt_out_q;
	logic            last_q;
	logic            trav_q;
	logic [dels_pkg::VAL_W-1:0] rd_data_q;

	logic            load;
	logic            produce;
	logic            full;
	logic            empty;
	logic [IW-1:0]   front_inc;
	logic [IW-1:0]   front_dec;
	logic [IW-1:0]   slot_inc;
	logic [SW-1:0]   back_sum;
	logic [IW-1:0]   back_slot;
	logic            wr_en;
	logic [IW-1:0]   wr_addr;
	logic            rd_en;
	logic [IW-1:0]   rd_addr;
	logic [dels_pkg::ST_W-1:0]  st_d;
	logic            last_d;
	logic            trav_d;

	assign load  = !out_valid_q || !out_stall;
	assign full  = (count_q >= FULL_CNT);
	assign empty = (count_q == '0);

	assign front_inc = (front_q == LAST_IDX) ? '0 : front_q + IW'(1);
	assign front_dec = (front_q == '0) ? LAST_IDX : front_q - IW'(1);
	assign slot_inc  = (slot_q == LAST_IDX) ? '0 : slot_q + IW'(1);

	// front + count stays below twice the depth, one subtract wraps it
	assign back_sum  = SW'(front_q) + SW'(count_q);
	assign back_slot = (back_sum >= SW'(DEPTH)) ? IW'(back_sum - SW'(DEPTH)) : IW'(back_sum);

	assign q_pop   = (state_q == B_IDLE) && q_head.valid && load;
	assign produce = q_pop || ((state_q == B_TRAV) && load);

	always_comb begin
		state_d = state_q;
		front_d = front_q;
		count_d = count_q;
		slot_d  = slot_q;
		left_d  = left_q;
		wr_en   = 1'b0;
		wr_addr = back_slot;
		rd_en   = 1'b0;
		rd_addr = front_q;
		st_d    = dels_pkg::ST_OK;
		last_d  = 1'b1;
		trav_d  = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				if (q_pop) begin
					unique case (q_head.req.op)
						dels_pkg::OP_PUSH_BACK: begin
							if (full) begin
								st_d = dels_pkg::ST_FULL;
							end else begin
								wr_en   = 1'b1;
								count_d = count_q + CW'(1);
							end
						end
						dels_pkg::OP_PUSH_FRONT: begin
							if (full) begin
								st_d = dels_pkg::ST_FULL;
							end else begin
								wr_en   = 1'b1;
								wr_addr = front_dec;
								front_d = front_dec;
								count_d = count_q + CW'(1);
							end
						end
						dels_pkg::OP_POP_BACK: begin
							if (empty) begin
								st_d = dels_pkg::ST_EMPTY;
							end else begin
								count_d = count_q - CW'(1);
							end
						end
						dels_pkg::OP_POP_FRONT: begin
							if (empty) begin
								st_d = dels_pkg::ST_EMPTY;
							end else begin
								front_d = front_inc;
								count_d = count_q - CW'(1);
							end
						end
						dels_pkg::OP_TRAVERSE: begin
							if (empty) begin
								st_d = dels_pkg::ST_EMPTY;
							end else begin
								// first entry goes out with the request itself
								rd_en  = 1'b1;
								trav_d = 1'b1;
								last_d = (count_q == CW'(1));
								slot_d = front_inc;
								left_d = count_q - CW'(1);
								if (count_q != CW'(1)) begin
									state_d = B_TRAV;
								end
							end
						end
						dels_pkg::OP_LENGTH: begin
							st_d = dels_pkg::ST_OK;
						end
						default: begin
							st_d = dels_pkg::ST_OK;
						end
					endcase
				end
			end
			B_TRAV: begin
				if (load) begin
					rd_en   = 1'b1;
					rd_addr = slot_q;
					trav_d  = 1'b1;
					last_d  = (left_q == CW'(1));
					slot_d  = slot_inc;
					left_d  = left_q - CW'(1);
					if (left_q == CW'(1)) begin
						state_d = B_IDLE;
					end
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	// the registered read data is the output value register
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= q_head.req.value;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (produce) begin
			status_q  <= st_d;
			cnt_out_q <= count_d;
			last_q    <= last_d;
			trav_q    <= trav_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			front_q     <= '0;
			count_q     <= '0;
			slot_q      <= '0;
			left_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			front_q <= front_d;
			count_q <= count_d;
			slot_q  <= slot_d;
			left_q  <= left_d;
			if (load) begin
				out_valid_q <= produce;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign item_value  = trav_q ? rd_data_q : '0;
	assign entry_count = cnt_out_q;
	assign last        = last_q;

endmodule

FILE: sv/double_ended_list_store.sv
// channel   | handshake               | fields
// ----------+-------------------------+------------------------------------------
// request   | in_valid / in_stall     | req_type, push_value
// result    | out_valid / out_stall   | status, item_value, entry_count, last
//
// push, pop and length give one result each, one request per cycle if not stalled
// traverse gives one result per stored entry, one per cycle if not stalled,
// read by the single value memory port whose read register is the output value
// a two-entry request queue parts the front from the back
// reset clears pointers, count and handshake state; the value memory is not cleared
// a stalled result holds in the output register while the two-entry queue fills
module double_ended_list_store #(
	parameter int DEPTH = dels_pkg::DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [dels_pkg::REQ_W-1:0]          req_type,
	input  logic signed [dels_pkg::VAL_W-1:0]   push_value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [dels_pkg::ST_W-1:0]           status,
	output logic signed [dels_pkg::VAL_W-1:0]   item_value,
	output logic [dels_pkg::CNT_W-1:0]          entry_count,
	output logic                                last
);

	dels_pkg::q_head_t q_head;
	logic              q_pop;

	dels_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.push_value (push_value),
		.q_head     (q_head),
		.q_pop      (q_pop)
	);

	dels_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.item_value  (item_value),
		.entry_count (entry_count),
		.last        (last)
	);

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (entry_count <= dels_pkg::CNT_W'(DEPTH)))
		else $error("entry count above depth");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == dels_pkg::ST_FULL)) |-> (entry_count == dels_pkg::CNT_W'(DEPTH)))
		else $error("full status without a full store");

	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == dels_pkg::ST_EMPTY)) |-> ((entry_count == '0) && last
			&& (item_value == '0)))
		else $error("empty status with entries or a value");

	a_midlist_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !last) |-> (status == dels_pkg::ST_OK))
		else $error("non-final result with error status");

	a_no_pop_while_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |-> !q_pop)
		else $error("request taken while result is held");
`endif

endmodule

FILE: verif/double_ended_list_store_tb.sv
module double_ended_list_store_tb;
	import dels_pkg::*;

	localparam int DEPTH           = DEPTH_DEF;
	localparam int RANDOM_REQUESTS = 40;
	localparam int LONG_HOLD       = 200;
	localparam int N_STEPS         = 25;

	// request codes the block has no meaning for
	localparam logic [REQ_W-1:0] REQ_SPARE_6 = 3'd6;
	localparam logic [REQ_W-1:0] REQ_SPARE_7 = 3'd7;

	typedef enum {OUT_FREE, OUT_LIGHT, OUT_HEAVY} stall_mode_t;

	typedef struct packed {
		logic [ST_W-1:0]         st;
		logic signed [VAL_W-1:0] val;
		logic [CNT_W-1:0]        cnt;
		logic                    lst;
	} result_t;

	// one directed step: request, repeat count, and where obvious the single result
	typedef struct packed {
		logic [REQ_W-1:0]        code;
		logic signed [VAL_W-1:0] val;
		logic                    rnd;
		logic [CNT_W-1:0]        reps;
		logic                    typed;
		logic [ST_W-1:0]         st;
		logic [CNT_W-1:0]        cnt;
	} step_t;

	step_t directed_steps [N_STEPS] = '{
		'{OP_TRAVERSE,   32'sd0,            1'b0, 7'd1,  1'b1, ST_EMPTY, 7'd0},
		'{OP_POP_BACK,   32'sd0,            1'b0, 7'd1,  1'b1, ST_EMPTY, 7'd0},
		'{OP_POP_FRONT,  32'sd0,            1'b0, 7'd1,  1'b1, ST_EMPTY, 7'd0},
		'{OP_LENGTH,     32'sd0,            1'b0, 7'd1,  1'b1, ST_OK,    7'd0},
		'{REQ_SPARE_6,   32'sd0,            1'b0, 7'd1,  1'b0, ST_OK,    7'd0},
		'{REQ_SPARE_7,   -32'sd1,           1'b0, 7'd1,  1'b0, ST_OK,    7'd0},
		'{OP_PUSH_BACK,  32'sh7fff_ffff,    1'b0, 7'd1,  1'b1, ST_OK,    7'd1},
		'{OP_PUSH_FRONT, 32'sh8000_0000,    1'b0, 7'd1,  1'b1, ST_OK,    7'd2},
		'{OP_PUSH_BACK,  32'sd0,            1'b0, 7'd1,  1'b0, ST_OK,    7'd0},
		'{OP_PUSH_FRONT, -32'sd1,           1'b0, 7'd1,  1'b0, ST_OK,    7'd0},
		'{OP_TRAVERSE,   32'sd0,            1'b0, 7'd1,  1'b0, ST_OK,    7'd0},
		'{OP_LENGTH,     32'sd0,            1'b0, 7'd1,  1'b1, ST_OK,    7'd4},
		'{OP_POP_BACK,   32'sd0,            1'b0, 7'd1,  1'b1, ST_OK,    7'd3},
		'{OP_POP_FRONT,  32'sd0,            1'b0, 7'd1,  1'b1, ST_OK,    7'd2},
		'{OP_TRAVERSE,   32'sd0,            1'b0, 7'd1,  1'b0, ST_OK,    7'd0},
		'{OP_POP_BACK,   32'sd0,            1'b0, 7'd1,  1'b1, ST_OK,    7'd1},
		'{OP_POP_FRONT,  32'sd0,            1'b0, 7'd1,  1'b1, ST_OK,    7'd0},
		'{OP_PUSH_FRONT, 32'sd5,            1'b0, 7'd1,  1'b0, ST_OK,    7'd0},
		'{OP_PUSH_BACK,  32'sd0,            1'b1, 7'd63, 1'b0, ST_OK,    7'd0},
		'{OP_PUSH_BACK,  32'sd9,            1'b0, 7'd1,  1'b1, ST_FULL,  7'd64},
		'{OP_PUSH_FRONT, 32'sd9,            1'b0, 7'd1,  1'b1, ST_FULL,  7'd64},
		'{OP_TRAVERSE,   32'sd0,            1'b0, 7'd1,  1'b0, ST_OK,    7'd0},
		'{OP_LENGTH,     32'sd0,            1'b0, 7'd1,  1'b1, ST_OK,    7'd64},
		'{OP_POP_FRONT,  32'sd0,            1'b0, 7'd63, 1'b0, ST_OK,    7'd0},
		'{OP_POP_BACK,   32'sd0,            1'b0, 7'd1,  1'b1, ST_OK,    7'd0}
	};

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic [REQ_W-1:0]         req_type = '0;
	logic signed [VAL_W-1:0]  push_value = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic [ST_W-1:0]          status;
	logic signed [VAL_W-1:0]  item_value;
	logic [CNT_W-1:0]         entry_count;
	logic                     last;

	// shadow copy of the deque
	logic signed [VAL_W-1:0]  shadow_vals [DEPTH];
	int unsigned              shadow_front = 0;
	int unsigned              shadow_count = 0;

	result_t                  awaited_results [$];
	int                       err_count = 0;
	int                       results_checked = 0;
	int                       requests_sent = 0;
	int                       full_pushes = 0;
	int                       empty_hits = 0;
	int                       hold_requests = 0;
	int                       holds_done = 0;
	int                       burst_left = 1;
	bit                       gapless = 1'b0;

	double_ended_list_store #(.DEPTH(DEPTH)) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.push_value  (push_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.item_value  (item_value),
		.entry_count (entry_count),
		.last        (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function void await_result(logic [ST_W-1:0] st, logic signed [VAL_W-1:0] v, logic lst);
		awaited_results.push_back('{st, v, shadow_count[CNT_W-1:0], lst});
	endfunction

	// updates the shadow deque and queues the results the request causes
	function void deque_apply(logic [REQ_W-1:0] code, logic signed [VAL_W-1:0] v);
		case (code) inside
			OP_PUSH_BACK, OP_PUSH_FRONT: begin
				if (shadow_count == DEPTH) begin
					full_pushes++;
					await_result(ST_FULL, '0, 1'b1);
				end else begin
					if (code == OP_PUSH_BACK) begin
						shadow_vals[(shadow_front + shadow_count) % DEPTH] = v;
					end else begin
						shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
						shadow_vals[shadow_front] = v;
					end
					shadow_count++;
					await_result(ST_OK, '0, 1'b1);
				end
			end
			OP_POP_BACK, OP_POP_FRONT: begin
				if (shadow_count == 0) begin
					empty_hits++;
					await_result(ST_EMPTY, '0, 1'b1);
				end else begin
					if (code == OP_POP_FRONT)
						shadow_front = (shadow_front + 1) % DEPTH;
					shadow_count--;
					await_result(ST_OK, '0, 1'b1);
				end
			end
			OP_TRAVERSE: begin
				if (shadow_count == 0) begin
					empty_hits++;
					await_result(ST_EMPTY, '0, 1'b1);
				end else begin
					for (int i = 0; i < shadow_count; i++)
						await_result(ST_OK, shadow_vals[(shadow_front + i) % DEPTH],
							i == shadow_count - 1);
				end
			end
			OP_LENGTH: await_result(ST_OK, '0, 1'b1);
			default: ;
		endcase
	endfunction

	function automatic logic signed [VAL_W-1:0] rand_value();
		case ($urandom_range(0, 9))
			0: return 32'sh7fff_ffff;
			1: return 32'sh8000_0000;
			2: return 32'sd0;
			3: return -32'sd1;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [REQ_W-1:0] pick_mixed();
		int r;
		r = $urandom_range(0, 99);
		if (r < 22) return OP_PUSH_BACK;
		if (r < 44) return OP_PUSH_FRONT;
		if (r < 58) return OP_POP_BACK;
		if (r < 72) return OP_POP_FRONT;
		// keep most traversals short
		if (r < 84) return (shadow_count <= 16) ? OP_TRAVERSE : OP_LENGTH;
		if (r < 94) return OP_LENGTH;
		if (r < 97) return REQ_SPARE_6;
		return REQ_SPARE_7;
	endfunction

	task automatic offer(input logic [REQ_W-1:0] code, input logic signed [VAL_W-1:0] v,
		input logic typed = 1'b0, input logic [ST_W-1:0] st = ST_OK,
		input logic [CNT_W-1:0] cnt = '0);
		int before_n;
		in_valid <= 1'b1;
		req_type <= code;
		push_value <= v;
		do @(posedge clk); while (in_stall);
		before_n = awaited_results.size();
		deque_apply(code, v);
		if (typed) begin
			while (awaited_results.size() > before_n)
				void'(awaited_results.pop_back());
			awaited_results.push_back('{st, '0, cnt, 1'b1});
		end
		if (code != REQ_SPARE_6 && code != REQ_SPARE_7)
			requests_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 12);
			if (!gapless) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (awaited_results.size() != 0);
	endtask

	initial begin
		int base;
		int kind;
		int fills_done;
		fills_done = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_steps[k]) begin
			for (int j = 0; j < directed_steps[k].reps; j++)
				offer(directed_steps[k].code,
					directed_steps[k].rnd ? rand_value() : directed_steps[k].val,
					directed_steps[k].typed, directed_steps[k].st, directed_steps[k].cnt);
		end
		drain_results();

		base = requests_sent;
		// receiver holds off while requests keep coming
		hold_requests++;
		gapless = 1'b1;
		repeat (12) offer(pick_mixed(), rand_value());
		gapless = 1'b0;

		while (requests_sent - base < RANDOM_REQUESTS) begin
			kind = $urandom_range(0, 5);
			gapless = ($urandom_range(0, 3) == 0);
			if (kind == 0 && fills_done < 2) begin
				fills_done++;
				while (shadow_count < DEPTH)
					offer($urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT, rand_value());
				repeat ($urandom_range(1, 3))
					offer($urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT, rand_value());
				offer(OP_TRAVERSE, rand_value());
			end else if (kind == 1) begin
				while (shadow_count > 0)
					offer($urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT, rand_value());
				repeat ($urandom_range(1, 2))
					offer($urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT, rand_value());
				offer(OP_TRAVERSE, rand_value());
				offer(OP_LENGTH, rand_value());
			end else begin
				repeat ($urandom_range(8, 30)) offer(pick_mixed(), rand_value());
			end
			if ($urandom_range(0, 3) == 0)
				drain_results();
		end

		drain_results();
		repeat (DEPTH + 8) @(posedge clk);
		$display("covered %0d requests and %0d results, %0d pushes into a full store,",
			requests_sent, results_checked, full_pushes);
		$display("%0d requests on an empty store, %0d long output hold-offs",
			empty_hits, holds_done);
		if (err_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// receiver: stall pattern in modes of random length, plus the long hold-off
	initial begin
		stall_mode_t mode;
		int          mode_left;
		mode = OUT_FREE;
		mode_left = 0;
		forever begin
			@(posedge clk);
			if (holds_done < hold_requests) begin
				holds_done++;
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				out_stall <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode = stall_mode_t'($urandom_range(0, 2));
					mode_left = $urandom_range(10, 60);
				end
				mode_left--;
				case (mode)
					OUT_FREE:  out_stall <= 1'b0;
					OUT_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
					default:   out_stall <= ($urandom_range(0, 9) < 7);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{status, item_value, entry_count, last};
			if (awaited_results.size() == 0) begin
				err_count++;
				$display("%0t: unexpected result, status %0d value %0d count %0d last %0d",
					$time, got.st, got.val, got.cnt, got.lst);
			end else begin
				want = awaited_results.pop_front();
				results_checked++;
				if (got !== want) begin
					err_count++;
					if (got.st !== want.st)
						$display("%0t: status expected %0d, got %0d", $time, want.st, got.st);
					if (got.val !== want.val)
						$display("%0t: item_value expected %0d, got %0d",
							$time, want.val, got.val);
					if (got.cnt !== want.cnt)
						$display("%0t: entry_count expected %0d, got %0d",
							$time, want.cnt, got.cnt);
					if (got.lst !== want.lst)
						$display("%0t: last expected %0d, got %0d", $time, want.lst, got.lst);
				end
			end
		end
	end

	initial begin
		#5_000_000;
		$display("timeout with %0d results still awaited", awaited_results.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule
